[sv/csmv_pkg.sv]
// Package for the compressed-row sparse matrix-vector accumulate block.
// Holds request codes, queue entry types and queue sizes; no dependencies.
package csmv_pkg;

	localparam logic [1:0] REQ_LOAD = 2'd0;
	localparam logic [1:0] REQ_MAC  = 2'd1;
	localparam logic [1:0] REQ_END  = 2'd2;

	localparam int WQ_DEPTH  = 4;
	localparam int OUT_DEPTH = 8;
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	typedef enum logic {
		OP_MAC = 1'b0,
		OP_END = 1'b1
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] a;
		logic [31:0] b;
	} work_t;

	typedef struct packed {
		logic [31:0] y_value;
		logic [15:0] row_number;
		logic        saturated;
	} result_t;

	typedef struct packed {
		logic  push;
		work_t entry;
	} work_push_t;

endpackage

[sv/csmv_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module csmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/csmv_fifo.sv]
// Generic first-word-fall-through queue built from registers.
// No dependencies.
module csmv_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       rd_en,
	output logic [WIDTH-1:0]           rdata,
	output logic                       is_empty,
	output logic                       is_full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign rdata    = mem_q[rd_ptr_q];
	assign count    = count_q;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/csmv_front.sv]
// Front end: accepts requests, writes loads into the x store and reads x for nonzeros.
// Depends on csmv_pkg and csmv_ram.
module csmv_front
	import csmv_pkg::*;
#(
	parameter int VECTOR_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [9:0]  index,
	input  logic [31:0] data,
	output work_push_t  wq,
	input  logic        wq_full
);

	localparam int AW = $clog2(VECTOR_DEPTH);

	logic          accept;
	logic          in_range;
	logic          is_load;
	logic          is_work;
	logic          adv;
	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] addr;
	logic [31:0]   x_rdata;

	logic          valid_s1;
	op_t           op_s1;
	logic [31:0]   data_s1;
	logic          inr_s1;

	always_comb begin
		is_load = 1'b0;
		is_work = 1'b0;
		unique case (req_type)
			REQ_LOAD: is_load = 1'b1;
			REQ_MAC:  is_work = 1'b1;
			REQ_END:  is_work = 1'b1;
			default: begin
				is_load = 1'b0;
				is_work = 1'b0;
			end
		endcase
	end

	assign adv      = !valid_s1 || !wq_full;
	assign full     = !adv;
	assign accept   = push && adv;
	assign in_range = (32'(index) < 32'(VECTOR_DEPTH));
	assign addr     = AW'(index);
	assign ram_we   = accept && is_load && in_range;
	assign ram_re   = accept && (req_type == REQ_MAC);

	csmv_ram #(
		.WIDTH (32),
		.DEPTH (VECTOR_DEPTH)
	) u_x_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (data),
		.re    (ram_re),
		.raddr (addr),
		.rdata (x_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept && is_work;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= (req_type == REQ_END) ? OP_END : OP_MAC;
			data_s1 <= data;
			inr_s1  <= in_range;
		end
	end

	always_comb begin
		wq.push    = valid_s1 && !wq_full;
		wq.entry.op = op_s1;
		wq.entry.a  = data_s1;
		wq.entry.b  = (op_s1 == OP_MAC && inr_s1) ? x_rdata : 32'd0;
	end

endmodule

[sv/csmv_back.sv]
// Back end: multiply-accumulate pipeline, row-end scaling, rounding and saturation.
// Depends on csmv_pkg.
module csmv_back
	import csmv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wq_empty,
	input  work_t             wq_head,
	output logic              wq_pop,
	input  logic [31:0]       scale,
	input  logic [OUT_CW-1:0] out_count,
	output logic              res_push,
	output result_t           res
);

	logic                    credit_ok;
	logic [OUT_CW-1:0]       inflight_q;
	logic [OUT_CW:0]         committed;

	logic signed [63:0]      acc_q;
	logic                    clip_q;
	logic [15:0]             row_q;
	logic signed [64:0]      sum65;

	logic                    valid_s1;
	op_t                     op_s1;
	logic signed [31:0]      a_s1;
	logic signed [31:0]      b_s1;

	logic                    valid_s2;
	op_t                     op_s2;
	logic signed [63:0]      prod_s2;
	logic [31:0]             a_s2;

	logic                    valid_s3;
	logic [63:0]             mag_s3;
	logic [31:0]             smag_s3;
	logic                    neg_s3;
	logic [31:0]             yold_s3;
	logic                    clip_s3;
	logic [15:0]             row_s3;

	logic                    valid_s4;
	logic [63:0]             plo_s4;
	logic [63:0]             phi_s4;
	logic                    neg_s4;
	logic [31:0]             yold_s4;
	logic                    clip_s4;
	logic [15:0]             row_s4;

	logic                    valid_s5;
	logic [63:0]             mid_s5;
	logic                    neg_s5;
	logic [31:0]             yold_s5;
	logic                    clip_s5;
	logic [15:0]             row_s5;

	logic                    valid_s6;
	logic signed [48:0]      qs_s6;
	logic [31:0]             yold_s6;
	logic                    clip_s6;
	logic [15:0]             row_s6;

	logic [47:0]             q;
	logic signed [49:0]      ysum;

	// Row ends only leave the queue when the result queue is sure to have room.
	assign committed = {1'b0, out_count} + {1'b0, inflight_q};
	assign credit_ok = (committed < (OUT_CW + 1)'(OUT_DEPTH));
	assign wq_pop    = !wq_empty && (wq_head.op == OP_MAC || credit_ok);

	assign sum65 = {acc_q[63], acc_q} + {prod_s2[63], prod_s2};
	assign q     = mid_s5[63:16] + 48'(mid_s5[15]);
	assign ysum  = 50'($signed(yold_s6)) + 50'(qs_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			valid_s4   <= 1'b0;
			valid_s5   <= 1'b0;
			valid_s6   <= 1'b0;
			acc_q      <= '0;
			clip_q     <= 1'b0;
			row_q      <= '0;
			inflight_q <= '0;
		end else begin
			valid_s1 <= wq_pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2 && op_s2 == OP_END;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			if (wq_pop && wq_head.op == OP_END && !valid_s6) begin
				inflight_q <= inflight_q + 1'b1;
			end else if (valid_s6 && !(wq_pop && wq_head.op == OP_END)) begin
				inflight_q <= inflight_q - 1'b1;
			end
			if (valid_s2) begin
				if (op_s2 == OP_END) begin
					acc_q  <= '0;
					clip_q <= 1'b0;
					row_q  <= row_q + 1'b1;
				end else if (sum65[64] != sum65[63]) begin
					acc_q  <= sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
					clip_q <= 1'b1;
				end else begin
					acc_q <= sum65[63:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wq_pop) begin
			op_s1 <= wq_head.op;
			a_s1  <= $signed(wq_head.a);
			b_s1  <= $signed(wq_head.b);
		end
		op_s2   <= op_s1;
		prod_s2 <= a_s1 * b_s1;
		a_s2    <= a_s1;

		mag_s3  <= acc_q[63] ? (~acc_q + 64'd1) : acc_q;
		smag_s3 <= scale[31] ? (~scale + 32'd1) : scale;
		neg_s3  <= acc_q[63] ^ scale[31];
		yold_s3 <= a_s2;
		clip_s3 <= clip_q;
		row_s3  <= row_q;

		plo_s4  <= 64'(mag_s3[31:0]) * 64'(smag_s3);
		phi_s4  <= 64'(mag_s3[63:32]) * 64'(smag_s3);
		neg_s4  <= neg_s3;
		yold_s4 <= yold_s3;
		clip_s4 <= clip_s3;
		row_s4  <= row_s3;

		mid_s5  <= phi_s4 + {32'd0, plo_s4[63:32]};
		neg_s5  <= neg_s4;
		yold_s5 <= yold_s4;
		clip_s5 <= clip_s4;
		row_s5  <= row_s4;

		qs_s6   <= neg_s5 ? -$signed({1'b0, q}) : $signed({1'b0, q});
		yold_s6 <= yold_s5;
		clip_s6 <= clip_s5;
		row_s6  <= row_s5;
	end

	always_comb begin
		res_push       = valid_s6;
		res.row_number = row_s6;
		if (ysum > 50'sd2147483647) begin
			res.y_value   = 32'h7FFF_FFFF;
			res.saturated = 1'b1;
		end else if (ysum < -50'sd2147483648) begin
			res.y_value   = 32'h8000_0000;
			res.saturated = 1'b1;
		end else begin
			res.y_value   = ysum[31:0];
			res.saturated = clip_s6;
		end
	end

endmodule

[sv/csr_sparse_matvec_accumulate.sv]
// Top level of the compressed-row sparse matrix-vector accumulate block.
// Depends on csmv_pkg, csmv_fifo, csmv_front and csmv_back.
//
// Usage:
// Requests enter through a queue-style port: push with full; a transaction
// completes when push is high and full is low. A load writes x[index], a
// nonzero adds data * x[index] into the row sum, and a row end returns
// y_old + scale * row_sum as one result transaction, then starts a new row.
// Results leave through empty and pop; the oldest result sits on y_value,
// row_number and saturated while empty is low.
// One request is taken every cycle, including back-to-back row ends, as long
// as results are drained. A row end's result passes the front stage, the
// work queue and a six-stage back pipeline whose row-end scaling splits the
// 64 by 32 product in two halves. A stalled receiver first fills the
// eight-entry result queue; after that, row ends wait in the four-entry work
// queue and full rises when it fills. Reset clears the row sum, the row
// counter and all queues and sets scale to 1.0; the x store holds no defined
// data until loaded. scale is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle; the block does not enforce it.
module csr_sparse_matvec_accumulate
	import csmv_pkg::*;
#(
	parameter int VECTOR_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [9:0]  index,
	input  logic [31:0] data,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] y_value,
	output logic [15:0] row_number,
	output logic        saturated
);

	localparam int WQ_CW = $clog2(WQ_DEPTH + 1);

	logic [31:0]       scale_q;
	work_push_t        wq;
	logic              wq_full;
	logic              wq_empty;
	logic              wq_pop;
	work_t             wq_head;
	logic [WQ_CW-1:0]  wq_count;
	logic              res_push;
	result_t           res_in;
	result_t           res_out;
	logic              res_full;
	logic              res_pop;
	logic [OUT_CW-1:0] res_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= 32'd65536;
		end else if (cfg_we) begin
			scale_q <= cfg_wdata;
		end
	end

	csmv_front #(
		.VECTOR_DEPTH (VECTOR_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.req_type (req_type),
		.index    (index),
		.data     (data),
		.wq       (wq),
		.wq_full  (wq_full)
	);

	csmv_fifo #(
		.WIDTH ($bits(work_t)),
		.DEPTH (WQ_DEPTH)
	) u_work_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wq.push),
		.wdata    (wq.entry),
		.rd_en    (wq_pop),
		.rdata    (wq_head),
		.is_empty (wq_empty),
		.is_full  (wq_full),
		.count    (wq_count)
	);

	csmv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wq_empty  (wq_empty),
		.wq_head   (wq_head),
		.wq_pop    (wq_pop),
		.scale     (scale_q),
		.out_count (res_count),
		.res_push  (res_push),
		.res       (res_in)
	);

	assign res_pop = pop && !empty;

	csmv_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_push),
		.wdata    (res_in),
		.rd_en    (res_pop),
		.rdata    (res_out),
		.is_empty (empty),
		.is_full  (res_full),
		.count    (res_count)
	);

	assign y_value    = res_out.y_value;
	assign row_number = res_out.row_number;
	assign saturated  = res_out.saturated;

`ifndef SYNTHESIS
	// The credit scheme must never let a result arrive at a full result queue.
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full || res_pop)
		else $error("result pushed into a full result queue");

	// The front stage must never push into a full work queue.
	a_wq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wq.push |-> !wq_full)
		else $error("work item pushed into a full work queue");

	// The input side stalls only when the work queue is full.
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> wq_count == WQ_CW'(WQ_DEPTH))
		else $error("input stalled while the work queue has room");
`endif

endmodule
